// ===== hw/rtl/bcd_pkg.sv =====
package bcd_pkg;

	localparam int unsigned TICK_W    = 16;
	localparam int unsigned SINCE_W   = 17;
	localparam int unsigned CLICK_W   = 4;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CLICK_W-1:0] CLICK_FIELD_MAX = '1;
	localparam logic [SINCE_W-1:0] SINCE_SAT       = '1;

	localparam int unsigned MAX_CLICKS_DEF = 15;

	localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [TICK_W-1:0] LONG_RST     = 16'd3000;
	localparam logic [TICK_W-1:0] GAP_RST      = 16'd500;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd2;

	localparam logic [KIND_W-1:0] EV_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] EV_CLICKS = 2'd1;
	localparam logic [KIND_W-1:0] EV_LONG   = 2'd2;

	typedef struct packed {
		logic [TICK_W-1:0] debounce_ticks;
		logic [TICK_W-1:0] long_press_ticks;
		logic [TICK_W-1:0] gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]  event_kind;
		logic [CLICK_W-1:0] clicks;
		logic               press_cue;
	} result_t;

endpackage

// ===== hw/rtl/bcd_engine.sv =====
module bcd_engine #(
	parameter int unsigned MAX_CLICKS = bcd_pkg::MAX_CLICKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            level,
	input  bcd_pkg::cfg_t    cfg,
	output bcd_pkg::result_t res
);
	import bcd_pkg::*;

	localparam logic [CLICK_W-1:0] TALLY_CAP =
		(MAX_CLICKS > int'(CLICK_FIELD_MAX)) ? CLICK_FIELD_MAX : CLICK_W'(MAX_CLICKS);

	logic               prev_level_q;
	logic               long_seen_q;
	logic [CLICK_W-1:0] click_tally_q;
	logic [SINCE_W-1:0] since_press_q;
	logic [TICK_W-1:0]  lockout_left_q;

	logic               prev_level_d;
	logic               long_seen_d;
	logic [CLICK_W-1:0] click_tally_d;
	logic [SINCE_W-1:0] since_press_d;
	logic [TICK_W-1:0]  lockout_left_d;

	logic [SINCE_W-1:0] since_inc;
	logic [TICK_W-1:0]  lockout_dec;
	logic               rise;
	logic               fall;
	logic               long_hit;

	always_comb begin
		since_inc   = (since_press_q == SINCE_SAT) ? since_press_q : since_press_q + 1'b1;
		lockout_dec = (lockout_left_q != '0) ? lockout_left_q - 1'b1 : lockout_left_q;
		rise        = level & ~prev_level_q;
		fall        = ~level & prev_level_q;

		prev_level_d   = prev_level_q;
		long_seen_d    = long_seen_q;
		click_tally_d  = click_tally_q;
		since_press_d  = since_inc;
		lockout_left_d = lockout_dec;
		long_hit       = 1'b0;
		res            = '{event_kind: EV_NONE, clicks: '0, press_cue: 1'b0};

		if (lockout_dec == '0) begin
			if (rise) begin
				since_press_d = '0;
				long_seen_d   = 1'b0;
				res.press_cue = 1'b1;
			end
			long_hit = level && (since_press_d > {1'b0, cfg.long_press_ticks}) && !long_seen_d;
			if (long_hit) begin
				res.press_cue  = 1'b1;
				res.event_kind = EV_LONG;
				long_seen_d    = 1'b1;
			end else begin
				if (fall) begin
					lockout_left_d = cfg.debounce_ticks;
					if (!long_seen_d) begin
						if (click_tally_d < TALLY_CAP) begin
							click_tally_d = click_tally_d + 1'b1;
						end
					end else begin
						click_tally_d = '0;
					end
				end
				if (!level && (since_press_d > {1'b0, cfg.gap_ticks}) && (click_tally_d != '0)) begin
					res.event_kind = EV_CLICKS;
					res.clicks     = click_tally_d;
					click_tally_d  = '0;
				end
			end
			prev_level_d = level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q   <= 1'b0;
			long_seen_q    <= 1'b0;
			click_tally_q  <= '0;
			since_press_q  <= SINCE_SAT;
			lockout_left_q <= '0;
		end else if (adv) begin
			prev_level_q   <= prev_level_d;
			long_seen_q    <= long_seen_d;
			click_tally_q  <= click_tally_d;
			since_press_q  <= since_press_d;
			lockout_left_q <= lockout_left_d;
		end
	end

endmodule

// ===== hw/rtl/button_click_and_long_press_decoder_top.sv =====
// Button click and long-press decoder. Each input transfer is one tick carrying the sampled
// button level and yields exactly one result transfer (event_kind, clicks, press_cue).
// Throughput is one tick per clock unless in_stall is high: the tick is registered; when it
// advances, the decoder state is updated and the result goes into a two-entry output queue.
// out_valid is high whenever the queue holds a result. Input stall rises only when the output
// queue is full and a registered tick is waiting. Configuration registers (0 debounce,
// 1 long press, 2 gap, all in ticks) may be written only while the block is idle; writes
// to other indices are dropped.
module button_click_and_long_press_decoder_top #(
	parameter int unsigned MAX_CLICKS = bcd_pkg::MAX_CLICKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [bcd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bcd_pkg::TICK_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           button_level,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bcd_pkg::KIND_W-1:0]     event_kind,
	output logic [bcd_pkg::CLICK_W-1:0]    clicks,
	output logic                           press_cue
);
	import bcd_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	logic    level_s1;
	logic    adv_s1;
	logic    push;
	logic    pop;
	result_t res;
	result_t queue_q [2];
	logic    rd_ptr_q;
	logic    wr_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= DEBOUNCE_RST;
			cfg_q.long_press_ticks <= LONG_RST;
			cfg_q.gap_ticks        <= GAP_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_DEBOUNCE: cfg_q.debounce_ticks   <= cfg_wdata;
				REG_LONG:     cfg_q.long_press_ticks <= cfg_wdata;
				REG_GAP:      cfg_q.gap_ticks        <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	assign in_stall  = valid_s1 && (count_q == 2'd2);
	assign adv_s1    = valid_s1 && (count_q != 2'd2);
	assign push      = adv_s1;
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			level_s1 <= button_level;
		end
	end

	bcd_engine #(
		.MAX_CLICKS(MAX_CLICKS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv_s1),
		.level  (level_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= res;
		end
	end

	assign event_kind = queue_q[rd_ptr_q].event_kind;
	assign clicks     = queue_q[rd_ptr_q].clicks;
	assign press_cue  = queue_q[rd_ptr_q].press_cue;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("output queue count out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid))
		else $error("input stalled without a waiting tick and full queue");

	a_clicks_only_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_kind != EV_CLICKS)) |-> (clicks == '0))
		else $error("click count on a non-burst result");

	a_long_cue: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_kind == EV_LONG)) |-> press_cue)
		else $error("long press without cue");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_kind == EV_NONE) || (event_kind == EV_CLICKS) ||
			(event_kind == EV_LONG)))
		else $error("illegal event kind");
`endif

endmodule
